>>> sv/stgr_pkg.sv
// Shared types, register indexes and helpers for the scaled glyph renderer.
`default_nettype none
package stgr_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
   localparam logic [2:0] REG_GLYPH_STRIDE = 3'd2;
   localparam logic [2:0] REG_COLUMN_GAP   = 3'd3;
   localparam logic [2:0] REG_LINE_GAP     = 3'd4;
   localparam logic [2:0] REG_HSCALE       = 3'd5;
   localparam logic [2:0] REG_VSCALE       = 3'd6;

   // Result kinds
   localparam logic [1:0] KIND_WINDOW = 2'd0;
   localparam logic [1:0] KIND_ROW    = 2'd1;
   localparam logic [1:0] KIND_STOP   = 2'd2;

   // Character codes
   localparam logic [7:0] CODE_LOW     = 8'd32;
   localparam logic [7:0] CODE_HIGH    = 8'd127;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   // Width of the value fed to the address reduction unit
   localparam int RED_W = 13;

   typedef struct packed {
      logic [4:0] glyph_width;
      logic [3:0] glyph_height;
      logic [5:0] glyph_stride;
      logic [3:0] column_gap;
      logic [3:0] line_gap;
      logic [2:0] horizontal_scale;
      logic [2:0] vertical_scale;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic write;
      logic stop;
      logic newline;
      logic place;
      logic window;
      logic read;
      logic fill;
      logic row;
      logic next_rep;
      logic next_row;
      logic advance;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic red_done;
      logic stopped;
      logic bottom_fail;
      logic newline;
      logic need_byte;
      logic rep_last;
      logic row_last;
   } sts_type;

   // Saturate a coordinate sum at 4095
   function automatic logic [11:0] sat_coord(input logic [12:0] v);
      sat_coord = v[12] ? 12'hFFF : v[11:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/stgr_datapath.sv
// Datapath: font store, cursor, address reduction, bit buffer and result registers.
`default_nettype none
module stgr_datapath #(
   parameter int FONT_BYTES      = 4096,
   parameter int MAX_GLYPH_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  stgr_pkg::cfg_type     cfg,
   input  stgr_pkg::cmd_type     cmd,
   output stgr_pkg::sts_type     sts,
   input  wire logic             req_mode,
   input  wire logic [11:0]      req_font_addr,
   input  wire logic [7:0]       req_font_byte,
   input  wire logic [7:0]       req_char_code,
   input  wire logic             req_first,
   input  wire logic [10:0]      req_left,
   input  wire logic [10:0]      req_top,
   input  wire logic [10:0]      req_right,
   input  wire logic [10:0]      req_bottom,
   output logic [1:0]            rsp_kind,
   output logic [11:0]           rsp_x_start,
   output logic [11:0]           rsp_y_start,
   output logic [11:0]           rsp_x_end,
   output logic [11:0]           rsp_y_end,
   output logic [63:0]           rsp_row_bits,
   output logic                  rsp_last
);
   import stgr_pkg::*;

   localparam int ADDR_W = $clog2(FONT_BYTES);
   localparam int BUF_W  = MAX_GLYPH_WIDTH + 8;
   localparam int CNT_W  = $clog2(BUF_W + 1);
   localparam logic [4:0] GW_MAX = 5'(MAX_GLYPH_WIDTH);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FONT_BYTES - 1);
   // Reciprocal of the store size; the estimated quotient is low by at most one
   localparam logic [RED_W-1:0] RECIP     = RED_W'((1 << RED_W) / FONT_BYTES);
   localparam logic [RED_W-1:0] FONT_SIZE = RED_W'(FONT_BYTES);
   localparam logic [3:0]       RED_STEPS = 4'd3;

   logic [7:0]        mem [FONT_BYTES];
   logic [7:0]        rd_ff;
   logic [7:0]        byte_ff;
   logic [7:0]        code_ff;
   logic [11:0]       cur_x_ff, cur_x_in;
   logic [11:0]       cur_y_ff, cur_y_in;
   logic [10:0]       left_ff, right_ff, bottom_ff;
   logic              stopped_ff;
   logic [RED_W-1:0]  rem_ff;
   logic [RED_W-1:0]  quo_ff;
   logic [3:0]        step_ff;
   logic [ADDR_W-1:0] ptr_ff;
   logic [BUF_W-1:0]  buf_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [3:0]        row_ff;
   logic [2:0]        rep_ff;

   logic [4:0]  gw;
   logic [3:0]  gh;
   logic [2:0]  xs, ys;
   logic [6:0]  w, xi, yi;
   logic [5:0]  h;
   logic [12:0] y_end_sum, x_end_sum, x_next, y_next;
   logic        wrap;
   logic [7:0]  code_map;
   logic [6:0]  code_idx;
   logic [12:0] base;
   logic [2*RED_W-1:0] prod;
   logic [MAX_GLYPH_WIDTH-1:0] top_bits;
   logic [63:0] mask;

   // Clamp the register values into their working ranges
   always_comb begin
      if (cfg.glyph_width == 5'd0)      gw = 5'd1;
      else if (cfg.glyph_width > GW_MAX) gw = GW_MAX;
      else                               gw = cfg.glyph_width;
      gh = (cfg.glyph_height == 4'd0) ? 4'd1 : cfg.glyph_height;
      if (cfg.horizontal_scale == 3'd0)     xs = 3'd1;
      else if (cfg.horizontal_scale > 3'd4) xs = 3'd4;
      else                                  xs = cfg.horizontal_scale;
      if (cfg.vertical_scale == 3'd0)     ys = 3'd1;
      else if (cfg.vertical_scale > 3'd4) ys = 3'd4;
      else                                ys = cfg.vertical_scale;
   end

   // Glyph footprint and cursor steps
   assign w  = 7'(gw) * 7'(xs);
   assign h  = 6'(gh) * 6'(ys);
   assign xi = 7'(gw + 5'(cfg.column_gap)) * 7'(xs);
   assign yi = 7'(5'(gh) + 5'(cfg.line_gap)) * 7'(ys);

   assign y_end_sum = {1'b0, cur_y_ff} + 13'(h) - 13'd1;
   assign x_end_sum = {1'b0, cur_x_ff} + 13'(w) - 13'd1;
   assign wrap      = x_end_sum > 13'(right_ff);
   assign x_next    = {1'b0, cur_x_ff} + 13'(xi);
   assign y_next    = {1'b0, cur_y_ff} + 13'(yi);

   // Glyph base address before reduction
   assign code_map = (code_ff < CODE_LOW || code_ff > CODE_HIGH) ? CODE_HIGH : code_ff;
   assign code_idx = 7'(code_map - CODE_LOW);
   assign base     = 13'(code_idx) * 13'(cfg.glyph_stride);

   // Quotient estimate by reciprocal multiplication
   assign prod = (2*RED_W)'(rem_ff) * (2*RED_W)'(RECIP);

   // Scale the next row of glyph bits across the row mask
   assign top_bits = buf_ff[BUF_W-1 -: MAX_GLYPH_WIDTH];
   always_comb begin
      mask = '0;
      for (int c = 0; c < MAX_GLYPH_WIDTH; c++) begin
         for (int j = 0; j < 4; j++) begin
            if (c < int'(gw) && j < int'(xs) && top_bits[MAX_GLYPH_WIDTH-1-c]) begin
               mask[6'(c * int'(xs) + j)] = 1'b1;
            end
         end
      end
   end

   // Cursor next value
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (cmd.capture && req_mode && req_first) begin
         cur_x_in = {1'b0, req_left};
         cur_y_in = {1'b0, req_top};
      end else if (cmd.newline || (cmd.place && wrap)) begin
         cur_x_in = {1'b0, left_ff};
         cur_y_in = sat_coord(y_next);
      end else if (cmd.advance) begin
         cur_x_in = sat_coord(x_next);
      end
   end

   assign sts.red_done    = (step_ff == 4'd0);
   assign sts.stopped     = stopped_ff;
   assign sts.bottom_fail = y_end_sum > 13'(bottom_ff);
   assign sts.newline     = (code_ff == NEWLINE_CODE);
   assign sts.need_byte   = cnt_ff < CNT_W'(gw);
   assign sts.rep_last    = (rep_ff == ys - 3'd1);
   assign sts.row_last    = (row_ff == gh - 4'd1);

   // Control state: cursor, region, stop flag and reduction counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         left_ff    <= '0;
         right_ff   <= '0;
         bottom_ff  <= '0;
         stopped_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         if (cmd.capture && req_mode && req_first) begin
            left_ff    <= req_left;
            right_ff   <= req_right;
            bottom_ff  <= req_bottom;
            stopped_ff <= 1'b0;
         end else if (cmd.stop) begin
            stopped_ff <= 1'b1;
         end
         if ((cmd.capture && !req_mode) || cmd.place) begin
            step_ff <= RED_STEPS;
         end else if (step_ff != 4'd0) begin
            step_ff <= step_ff - 4'd1;
         end
      end
   end

   // Reduce an address modulo the store size: estimate, subtract, correct
   always_ff @(posedge clock) begin
      if (cmd.capture && !req_mode) begin
         rem_ff <= RED_W'(req_font_addr);
      end else if (cmd.place) begin
         rem_ff <= base;
      end else if (step_ff == 4'd3) begin
         quo_ff <= prod[2*RED_W-1:RED_W];
      end else if (step_ff == 4'd2) begin
         rem_ff <= rem_ff - quo_ff * FONT_SIZE;
      end else if (step_ff == 4'd1 && int'(rem_ff) >= FONT_BYTES) begin
         rem_ff <= rem_ff - FONT_SIZE;
      end
   end

   // Item payload, bit buffer and row counters
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_font_byte;
         code_ff <= req_char_code;
      end
      if (cmd.window) begin
         ptr_ff <= ADDR_W'(rem_ff);
         buf_ff <= '0;
         cnt_ff <= '0;
         row_ff <= '0;
      end else if (cmd.read) begin
         ptr_ff <= (ptr_ff == ADDR_LAST) ? '0 : ptr_ff + 1'b1;
      end else if (cmd.fill) begin
         buf_ff <= buf_ff | (BUF_W'(rd_ff) << (CNT_W'(MAX_GLYPH_WIDTH) - cnt_ff));
         cnt_ff <= cnt_ff + CNT_W'(8);
      end else if (cmd.row) begin
         buf_ff <= buf_ff << gw;
         cnt_ff <= cnt_ff - CNT_W'(gw);
      end else if (cmd.next_row) begin
         row_ff <= row_ff + 4'd1;
      end
      if (cmd.row) begin
         rep_ff <= '0;
      end else if (cmd.next_rep) begin
         rep_ff <= rep_ff + 3'd1;
      end
   end

   // Font store
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[ADDR_W'(rem_ff)] <= byte_ff;
      end
      if (cmd.read) begin
         rd_ff <= mem[ptr_ff];
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.stop) begin
         rsp_kind     <= KIND_STOP;
         rsp_x_start  <= '0;
         rsp_y_start  <= '0;
         rsp_x_end    <= '0;
         rsp_y_end    <= '0;
         rsp_row_bits <= '0;
         rsp_last     <= 1'b1;
      end else if (cmd.window) begin
         rsp_kind     <= KIND_WINDOW;
         rsp_x_start  <= cur_x_ff;
         rsp_y_start  <= cur_y_ff;
         rsp_x_end    <= sat_coord(x_end_sum);
         rsp_y_end    <= sat_coord(y_end_sum);
         rsp_row_bits <= '0;
         rsp_last     <= 1'b0;
      end else if (cmd.row) begin
         rsp_kind     <= KIND_ROW;
         rsp_x_start  <= '0;
         rsp_y_start  <= '0;
         rsp_x_end    <= '0;
         rsp_y_end    <= '0;
         rsp_row_bits <= mask;
         rsp_last     <= sts.row_last && (ys == 3'd1);
      end else if (cmd.next_rep) begin
         rsp_last     <= sts.row_last && (rep_ff + 3'd1 == ys - 3'd1);
      end
   end

endmodule
`default_nettype wire

>>> sv/stgr_ctrl.sv
// Controller state machine sequencing loads, checks, windows and glyph rows.
`default_nettype none
module stgr_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_mode,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  stgr_pkg::sts_type  sts,
   output stgr_pkg::cmd_type  cmd
);
   import stgr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_BASE,
      S_WIN,
      S_NEED,
      S_FILL,
      S_ROW,
      S_STOP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_WIN) || (state_ff == S_ROW) || (state_ff == S_STOP);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = req_mode ? S_CHECK : S_LOAD;
            end
         end
         S_LOAD: begin
            if (sts.red_done) begin
               cmd.write = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CHECK: begin
            if (sts.stopped) begin
               state_in = S_IDLE;
            end else if (sts.bottom_fail) begin
               cmd.stop = 1'b1;
               state_in = S_STOP;
            end else if (sts.newline) begin
               cmd.newline = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_BASE;
            end
         end
         S_BASE: begin
            if (sts.red_done) begin
               cmd.window = 1'b1;
               state_in   = S_WIN;
            end
         end
         S_WIN: begin
            if (!rsp_stall) state_in = S_NEED;
         end
         S_NEED: begin
            if (sts.need_byte) begin
               cmd.read = 1'b1;
               state_in = S_FILL;
            end else begin
               cmd.row  = 1'b1;
               state_in = S_ROW;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_NEED;
         end
         S_ROW: begin
            if (!rsp_stall) begin
               if (!sts.rep_last) begin
                  cmd.next_rep = 1'b1;
               end else if (sts.row_last) begin
                  cmd.advance = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.next_row = 1'b1;
                  state_in     = S_NEED;
               end
            end
         end
         S_STOP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/scaled_text_glyph_render_core.sv
// Top level: configuration registers, controller and datapath of the glyph renderer.
`default_nettype none
// Draws a character stream as scaled bitmap-font glyph rows. A load transfer
// (mode 0) writes one font byte once its address has passed the address
// reduction unit that folds addresses modulo FONT_BYTES by a reciprocal
// multiply, a subtract and one correction step. A render transfer gives no
// result for a newline or a stopped string and a stop result on a bottom
// stop; otherwise the window result follows the base address reduction, then
// per glyph row 0 to 2 font store reads (one read port), the row load, and
// vertical_scale row results, each result held until the downstream side
// takes it. One item is in work at a time; the input stalls until its last
// result is taken. The font store has no reset; read only glyphs whose bytes
// were loaded. Write configuration only while idle.
module scaled_text_glyph_render_core #(
   parameter int FONT_BYTES      = 4096,
   parameter int MAX_GLYPH_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [11:0] req_font_addr,
   input  wire logic [7:0]  req_font_byte,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_first,
   input  wire logic [10:0] req_left,
   input  wire logic [10:0] req_top,
   input  wire logic [10:0] req_right,
   input  wire logic [10:0] req_bottom,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [11:0]      rsp_x_start,
   output logic [11:0]      rsp_y_start,
   output logic [11:0]      rsp_x_end,
   output logic [11:0]      rsp_y_end,
   output logic [63:0]      rsp_row_bits,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import stgr_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   sts_type    sts;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_width      <= 5'd5;
         cfg_ff.glyph_height     <= 4'd7;
         cfg_ff.glyph_stride     <= 6'd5;
         cfg_ff.column_gap       <= 4'd1;
         cfg_ff.line_gap         <= 4'd1;
         cfg_ff.horizontal_scale <= 3'd1;
         cfg_ff.vertical_scale   <= 3'd1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GLYPH_WIDTH:  cfg_ff.glyph_width      <= csr_pwdata[4:0];
            REG_GLYPH_HEIGHT: cfg_ff.glyph_height     <= csr_pwdata[3:0];
            REG_GLYPH_STRIDE: cfg_ff.glyph_stride     <= csr_pwdata[5:0];
            REG_COLUMN_GAP:   cfg_ff.column_gap       <= csr_pwdata[3:0];
            REG_LINE_GAP:     cfg_ff.line_gap         <= csr_pwdata[3:0];
            REG_HSCALE:       cfg_ff.horizontal_scale <= csr_pwdata[2:0];
            REG_VSCALE:       cfg_ff.vertical_scale   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // Register read back
   always_comb begin
      unique case (csr_idx)
         REG_GLYPH_WIDTH:  csr_prdata = 32'(cfg_ff.glyph_width);
         REG_GLYPH_HEIGHT: csr_prdata = 32'(cfg_ff.glyph_height);
         REG_GLYPH_STRIDE: csr_prdata = 32'(cfg_ff.glyph_stride);
         REG_COLUMN_GAP:   csr_prdata = 32'(cfg_ff.column_gap);
         REG_LINE_GAP:     csr_prdata = 32'(cfg_ff.line_gap);
         REG_HSCALE:       csr_prdata = 32'(cfg_ff.horizontal_scale);
         REG_VSCALE:       csr_prdata = 32'(cfg_ff.vertical_scale);
         default:          csr_prdata = '0;
      endcase
   end

   stgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stgr_datapath #(
      .FONT_BYTES      (FONT_BYTES),
      .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .sts           (sts),
      .req_mode      (req_mode),
      .req_font_addr (req_font_addr),
      .req_font_byte (req_font_byte),
      .req_char_code (req_char_code),
      .req_first     (req_first),
      .req_left      (req_left),
      .req_top       (req_top),
      .req_right     (req_right),
      .req_bottom    (req_bottom),
      .rsp_kind      (rsp_kind),
      .rsp_x_start   (rsp_x_start),
      .rsp_y_start   (rsp_y_start),
      .rsp_x_end     (rsp_x_end),
      .rsp_y_end     (rsp_y_end),
      .rsp_row_bits  (rsp_row_bits),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire
